// ----- rtl/cbb_pkg.sv -----
// Shared constants, types and helpers for the cubic B-spline basis evaluator.
package cbb_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int KNOT_W        = 24;
  localparam int NUM_KNOTS     = 5;
  localparam int DEGREE        = 3;
  localparam int OUT_FRAC      = 16;
  localparam int OUT_W         = 17;
  localparam logic [OUT_W-1:0] ONE_OUT = 17'h10000;

  // Data carried alongside the triangle nodes through every stage.
  typedef struct packed {
    logic [KNOT_W-1:0]                  u;
    logic [NUM_KNOTS-1:0][KNOT_W-1:0]   k;
    logic [1:0]                         span;
    logic                               err;
    logic                               sup;
  } side_t;

  // Cycles from start to result strobe.
  function automatic int pipe_latency(input int frac_bits);
    pipe_latency = DEGREE * (frac_bits + 4) + 3;
  endfunction

endpackage

// ----- rtl/cbb_div.sv -----
// Pipelined restoring divider, one quotient bit per stage.
module cbb_div #(
  parameter int QW = 17,
  parameter int DW = 24
) (
  input  logic               clk,
  input  logic [QW+DW-1:0]   dividend,
  input  logic [DW-1:0]      divisor,
  output logic [QW-1:0]      quotient
);

  logic [DW-1:0] rem_r  [QW];
  logic [QW-1:0] low_r  [QW];
  logic [QW-1:0] quo_r  [QW];
  logic [DW-1:0] den_r  [QW];

  for (genvar s = 0; s < QW; s++) begin : g_stage
    logic [DW-1:0] rem_in;
    logic [QW-1:0] low_in;
    logic [QW-1:0] quo_in;
    logic [DW-1:0] den_in;
    logic [DW:0]   trial;
    logic [DW:0]   diff;
    logic [DW-1:0] rem_nxt;
    logic          qbit;

    if (s == 0) begin : g_first
      // top bits of the dividend are already below the divisor
      assign rem_in = dividend[QW+DW-1:QW];
      assign low_in = dividend[QW-1:0];
      assign quo_in = '0;
      assign den_in = divisor;
    end else begin : g_next
      assign rem_in = rem_r[s-1];
      assign low_in = low_r[s-1];
      assign quo_in = quo_r[s-1];
      assign den_in = den_r[s-1];
    end

    always_comb begin
      trial   = {rem_in, low_in[QW-1]};
      diff    = trial - {1'b0, den_in};
      qbit    = (trial >= {1'b0, den_in});
      rem_nxt = qbit ? diff[DW-1:0] : trial[DW-1:0];
    end

    always_ff @(posedge clk) begin
      rem_r[s] <= rem_nxt;
      low_r[s] <= {low_in[QW-2:0], 1'b0};
      quo_r[s] <= {quo_in[QW-2:0], qbit};
      den_r[s] <= den_in;
    end
  end

  assign quotient = quo_r[QW-1];

endmodule

// ----- rtl/cbb_weigh.sv -----
// One weighted triangle term: floor(node * clamp(num) / den), zero for an empty interval.
module cbb_weigh #(
  parameter int FRAC_BITS = cbb_pkg::FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic [FRAC_BITS:0]          node,
  input  logic [cbb_pkg::KNOT_W-1:0]  num_a,
  input  logic [cbb_pkg::KNOT_W-1:0]  num_b,
  input  logic [cbb_pkg::KNOT_W-1:0]  den_a,
  input  logic [cbb_pkg::KNOT_W-1:0]  den_b,
  output logic [FRAC_BITS:0]          term
);

  localparam int NW = FRAC_BITS + 1;
  localparam int KW = cbb_pkg::KNOT_W;

  logic signed [KW:0] num_s;
  logic signed [KW:0] den_s;
  logic [KW-1:0]      num_nxt;
  logic [KW-1:0]      den_nxt;

  logic [NW-1:0]      node_r;
  logic [KW-1:0]      num_r;
  logic [KW-1:0]      den_r;
  logic [NW+KW-1:0]   prod_r;
  logic [KW-1:0]      den2_r;

  always_comb begin
    num_s = {num_a[KW-1], num_a} - {num_b[KW-1], num_b};
    den_s = {den_a[KW-1], den_a} - {den_b[KW-1], den_b};
    if (den_s <= 0) begin
      // empty interval: 0/1 gives a zero term
      num_nxt = '0;
      den_nxt = KW'(1);
    end else begin
      den_nxt = den_s[KW-1:0];
      if (num_s < 0) begin
        num_nxt = '0;
      end else if (num_s > den_s) begin
        num_nxt = den_s[KW-1:0];
      end else begin
        num_nxt = num_s[KW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    node_r <= node;
    num_r  <= num_nxt;
    den_r  <= den_nxt;
    prod_r <= (NW+KW)'(node_r) * (NW+KW)'(num_r);
    den2_r <= den_r;
  end

  cbb_div #(.QW(NW), .DW(KW)) u_div (
    .clk      (clk),
    .dividend (prod_r),
    .divisor  (den2_r),
    .quotient (term)
  );

endmodule

// ----- rtl/cbb_level.sv -----
// One row of the Cox-de Boor triangle: weighs, node sums and the matching side delay.
module cbb_level #(
  parameter int FRAC_BITS = cbb_pkg::FRAC_BITS_DEF,
  parameter int DEG_P     = 1
) (
  input  logic                                       clk,
  input  logic                                       rst_n,
  input  logic                                       in_vld,
  input  cbb_pkg::side_t                             in_side,
  input  logic [cbb_pkg::DEGREE-DEG_P+1:0][FRAC_BITS:0] in_node,
  output logic                                       out_vld,
  output cbb_pkg::side_t                             out_side,
  output logic [cbb_pkg::DEGREE-DEG_P:0][FRAC_BITS:0]   out_node
);

  localparam int NW   = FRAC_BITS + 1;
  localparam int NOUT = cbb_pkg::DEGREE - DEG_P + 1;
  localparam int LAT  = FRAC_BITS + 4;

  logic [NOUT-1:0][NW-1:0] node_r;
  logic                    vld_r  [LAT];
  cbb_pkg::side_t          side_r [LAT];

  for (genvar j = 0; j < NOUT; j++) begin : g_node
    logic [NW-1:0] left;
    logic [NW-1:0] right;
    logic [NW:0]   sum;

    cbb_weigh #(.FRAC_BITS(FRAC_BITS)) u_left (
      .clk   (clk),
      .node  (in_node[j]),
      .num_a (in_side.u),
      .num_b (in_side.k[j]),
      .den_a (in_side.k[j+DEG_P]),
      .den_b (in_side.k[j]),
      .term  (left)
    );

    cbb_weigh #(.FRAC_BITS(FRAC_BITS)) u_right (
      .clk   (clk),
      .node  (in_node[j+1]),
      .num_a (in_side.k[j+DEG_P+1]),
      .num_b (in_side.u),
      .den_a (in_side.k[j+DEG_P+1]),
      .den_b (in_side.k[j+1]),
      .term  (right)
    );

    // node sums never exceed 1.0
    assign sum = {1'b0, left} + {1'b0, right};

    always_ff @(posedge clk) begin
      node_r[j] <= sum[NW-1:0];
    end
  end

  for (genvar s = 0; s < LAT; s++) begin : g_dly
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s] <= 1'b0;
      end else begin
        vld_r[s] <= (s == 0) ? in_vld : vld_r[(s == 0) ? 0 : s-1];
      end
      side_r[s] <= (s == 0) ? in_side : side_r[(s == 0) ? 0 : s-1];
    end
  end

  assign out_vld  = vld_r[LAT-1];
  assign out_side = side_r[LAT-1];
  assign out_node = node_r;

endmodule

// ----- rtl/cubic_bspline_basis_eval.sv -----
// Top level: cubic B-spline basis N_0,3 evaluator, fully pipelined.
//
//  channel  | handshake         | payload
//  ---------+-------------------+-------------------------------------------------
//  input    | start / busy      | in_param_u, in_knot_0 .. in_knot_4
//  result   | out_valid strobe  | out_basis_value, out_in_support, out_span_index,
//           |                   | out_knot_order_error
//
// One transaction per cycle; busy is always low. The pipeline holds three triangle rows
// of bit-per-stage dividers.
// Reset clears the valid bits only; transactions in flight are dropped.
// The receiver cannot stall, so nothing in the pipeline ever holds.
module cubic_bspline_basis_eval #(
  parameter int FRAC_BITS = cbb_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [cbb_pkg::KNOT_W-1:0] in_param_u,
  input  logic signed [cbb_pkg::KNOT_W-1:0] in_knot_0,
  input  logic signed [cbb_pkg::KNOT_W-1:0] in_knot_1,
  input  logic signed [cbb_pkg::KNOT_W-1:0] in_knot_2,
  input  logic signed [cbb_pkg::KNOT_W-1:0] in_knot_3,
  input  logic signed [cbb_pkg::KNOT_W-1:0] in_knot_4,
  output logic                          out_valid,
  output logic [cbb_pkg::OUT_W-1:0]     out_basis_value,
  output logic                          out_in_support,
  output logic [1:0]                    out_span_index,
  output logic                          out_knot_order_error
);

  localparam int NW = FRAC_BITS + 1;
  localparam int KW = cbb_pkg::KNOT_W;
  localparam int SW = NW + cbb_pkg::OUT_FRAC;

  // input register
  logic                                       in_vld_r;
  logic [cbb_pkg::NUM_KNOTS-1:0][KW-1:0]      k_r;
  logic [KW-1:0]                              u_r;

  // classify stage
  cbb_pkg::side_t    side_nxt;
  cbb_pkg::side_t    side0_r;
  logic              vld0_r;
  logic [3:0][NW-1:0] node_nxt;
  logic [3:0][NW-1:0] node0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= start;
    end
    u_r    <= in_param_u;
    k_r[0] <= in_knot_0;
    k_r[1] <= in_knot_1;
    k_r[2] <= in_knot_2;
    k_r[3] <= in_knot_3;
    k_r[4] <= in_knot_4;
  end

  always_comb begin
    side_nxt.u   = u_r;
    side_nxt.k   = k_r;
    side_nxt.err = 1'b0;
    for (int i = 0; i < cbb_pkg::NUM_KNOTS - 1; i++) begin
      if ($signed(k_r[i]) > $signed(k_r[i+1])) begin
        side_nxt.err = 1'b1;
      end
    end
    side_nxt.sup = ($signed(u_r) >= $signed(k_r[0])) && ($signed(u_r) < $signed(k_r[4]));
    side_nxt.span = 2'd0;
    for (int i = 0; i < 4; i++) begin
      if ($signed(k_r[i]) <= $signed(u_r)) begin
        side_nxt.span = 2'(i);
      end
    end
    node_nxt = '0;
    node_nxt[side_nxt.span] = NW'(1) << FRAC_BITS;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld0_r <= 1'b0;
    end else begin
      vld0_r <= in_vld_r;
    end
    side0_r <= side_nxt;
    node0_r <= node_nxt;
  end

  // triangle rows
  logic               vld1, vld2, vld3;
  cbb_pkg::side_t     side1, side2, side3;
  logic [2:0][NW-1:0] node1;
  logic [1:0][NW-1:0] node2;
  logic [0:0][NW-1:0] node3;

  cbb_level #(.FRAC_BITS(FRAC_BITS), .DEG_P(1)) u_lvl1 (
    .clk (clk), .rst_n (rst_n),
    .in_vld (vld0_r), .in_side (side0_r), .in_node (node0_r),
    .out_vld (vld1), .out_side (side1), .out_node (node1)
  );

  cbb_level #(.FRAC_BITS(FRAC_BITS), .DEG_P(2)) u_lvl2 (
    .clk (clk), .rst_n (rst_n),
    .in_vld (vld1), .in_side (side1), .in_node (node1),
    .out_vld (vld2), .out_side (side2), .out_node (node2)
  );

  cbb_level #(.FRAC_BITS(FRAC_BITS), .DEG_P(3)) u_lvl3 (
    .clk (clk), .rst_n (rst_n),
    .in_vld (vld2), .in_side (side2), .in_node (node2),
    .out_vld (vld3), .out_side (side3), .out_node (node3)
  );

  // scale to Q1.16 and saturate
  logic [SW-1:0]                 scaled;
  logic [cbb_pkg::OUT_W-1:0]     basis_nxt;
  logic                          ok;

  if (FRAC_BITS >= cbb_pkg::OUT_FRAC) begin : g_shr
    assign scaled = SW'(node3[0]) >> (FRAC_BITS - cbb_pkg::OUT_FRAC);
  end else begin : g_shl
    assign scaled = SW'(node3[0]) << (cbb_pkg::OUT_FRAC - FRAC_BITS);
  end

  always_comb begin
    ok = !side3.err && side3.sup;
    if (!ok) begin
      basis_nxt = '0;
    end else if (scaled > SW'(cbb_pkg::ONE_OUT)) begin
      basis_nxt = cbb_pkg::ONE_OUT;
    end else begin
      basis_nxt = scaled[cbb_pkg::OUT_W-1:0];
    end
  end

  logic                      out_valid_r;
  logic [cbb_pkg::OUT_W-1:0] basis_r;
  logic                      sup_r;
  logic [1:0]                span_r;
  logic                      err_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= vld3;
    end
    basis_r <= basis_nxt;
    sup_r   <= side3.sup;
    span_r  <= ok ? side3.span : 2'd0;
    err_r   <= side3.err;
  end

  assign busy                 = 1'b0;
  assign out_valid            = out_valid_r;
  assign out_basis_value      = basis_r;
  assign out_in_support       = sup_r;
  assign out_span_index       = span_r;
  assign out_knot_order_error = err_r;

endmodule

// ----- rtl/cbb_checker.sv -----
// Port-level checks for the basis evaluator, bound to the top level.
module cbb_checker #(
  parameter int FRAC_BITS = cbb_pkg::FRAC_BITS_DEF
) (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          start,
  input logic                          busy,
  input logic [cbb_pkg::KNOT_W-1:0]    in_param_u,
  input logic [cbb_pkg::KNOT_W-1:0]    in_knot_0,
  input logic [cbb_pkg::KNOT_W-1:0]    in_knot_1,
  input logic [cbb_pkg::KNOT_W-1:0]    in_knot_2,
  input logic [cbb_pkg::KNOT_W-1:0]    in_knot_3,
  input logic [cbb_pkg::KNOT_W-1:0]    in_knot_4,
  input logic                          out_valid,
  input logic [cbb_pkg::OUT_W-1:0]     out_basis_value,
  input logic                          out_in_support,
  input logic [1:0]                    out_span_index,
  input logic                          out_knot_order_error
);

  localparam int LAT = cbb_pkg::pipe_latency(FRAC_BITS);

  // every accepted transaction yields a strobe after the fixed latency
  a_lat_hit: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##LAT out_valid)
    else $error("missing result strobe");

  a_lat_none: assert property (@(posedge clk) disable iff (!rst_n)
    !(start && !busy) |-> ##LAT !out_valid)
    else $error("result strobe without transaction");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_knot_order_error) |-> (out_basis_value == '0 && out_span_index == 2'd0))
    else $error("order error with nonzero result");

  a_sup_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_in_support) |-> (out_basis_value == '0 && out_span_index == 2'd0))
    else $error("nonzero result outside support");

  a_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_basis_value <= cbb_pkg::ONE_OUT))
    else $error("basis value above one");

endmodule

bind cubic_bspline_basis_eval cbb_checker #(.FRAC_BITS(FRAC_BITS)) u_cbb_checker (.*);

// ----- tb/tb_top.sv -----
// Testbench for the cubic B-spline basis evaluator: directed and random stimulus, scoreboard.
`timescale 1ns / 1ps
module tb_top;

  localparam int FB = cbb_pkg::FRAC_BITS_DEF;
  localparam int KNOT_W = cbb_pkg::KNOT_W;
  localparam int OUT_W = cbb_pkg::OUT_W;
  localparam int OUT_FRAC = cbb_pkg::OUT_FRAC;
  localparam logic [OUT_W-1:0] ONE_OUT = cbb_pkg::ONE_OUT;
  localparam int LAT = cbb_pkg::pipe_latency(FB);
  localparam int WATCHDOG_LIMIT = 5000;

  typedef struct {
    logic [OUT_W-1:0] basis;
    logic             sup;
    logic [1:0]       span;
    logic             err;
  } basis_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic signed [KNOT_W-1:0] in_param_u = '0;
  logic signed [KNOT_W-1:0] in_knot_0 = '0, in_knot_1 = '0, in_knot_2 = '0;
  logic signed [KNOT_W-1:0] in_knot_3 = '0, in_knot_4 = '0;
  logic out_valid;
  logic [OUT_W-1:0] out_basis_value;
  logic out_in_support;
  logic [1:0] out_span_index;
  logic out_knot_order_error;

  basis_res_t expected_q[$];
  int n_fail = 0, n_sent = 0, n_recv = 0, n_support = 0, n_order_err = 0;
  int idle_cycles = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  cubic_bspline_basis_eval #(.FRAC_BITS(FB)) u_top (
    .clk, .rst_n, .start, .busy, .in_param_u, .in_knot_0, .in_knot_1, .in_knot_2,
    .in_knot_3, .in_knot_4, .out_valid, .out_basis_value, .out_in_support,
    .out_span_index, .out_knot_order_error
  );

  // Alpha-weighted node: floor(node*num/den), num clamped to [0,den].
  function automatic longint unsigned weigh_node(longint unsigned node, longint num,
                                                 longint den);
    if (node == 0 || den <= 0) return 0;
    if (num < 0) num = 0;
    if (num > den) num = den;
    return (node * longint'(num)) / longint'(den);
  endfunction

  function automatic basis_res_t eval_basis(logic signed [KNOT_W-1:0] u_in,
                                            logic signed [KNOT_W-1:0] kn [5]);
    basis_res_t r;
    longint u, k[5];
    longint unsigned n[4];
    longint unsigned val;
    int span;
    u = u_in;
    for (int i = 0; i < 5; i++) k[i] = kn[i];
    r.err = 1'b0;
    for (int i = 0; i < 4; i++) if (k[i] > k[i+1]) r.err = 1'b1;
    r.sup = (u >= k[0]) && (u < k[4]);
    span = 0;
    val = 0;
    if (!r.err && r.sup) begin
      for (int i = 0; i < 4; i++) begin
        n[i] = 0;
        if (k[i] <= u) span = i;
      end
      n[span] = 64'd1 << FB;
      for (int p = 1; p <= 3; p++)
        for (int j = 0; j + p <= 3; j++)
          n[j] = weigh_node(n[j], u - k[j], k[j+p] - k[j]) +
                 weigh_node(n[j+1], k[j+p+1] - u, k[j+p+1] - k[j+1]);
      val = (FB >= OUT_FRAC) ? (n[0] >> (FB - OUT_FRAC)) : (n[0] << (OUT_FRAC - FB));
      if (val > ONE_OUT) val = ONE_OUT;
    end
    r.basis = val[OUT_W-1:0];
    r.span = span[1:0];
    return r;
  endfunction

  // Sends one transaction after a random gap; keeps start high across back-to-back items.
  task automatic send_eval(logic signed [KNOT_W-1:0] u, logic signed [KNOT_W-1:0] kn [5]);
    int gap;
    gap = $urandom_range(0, 10);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_param_u <= u;
    in_knot_0 <= kn[0]; in_knot_1 <= kn[1]; in_knot_2 <= kn[2];
    in_knot_3 <= kn[3]; in_knot_4 <= kn[4];
    do @(posedge clk); while (busy);
    expected_q.insert(expected_q.size(), eval_basis(u, kn));
    n_sent++;
  endtask

  task automatic finish_send();
    start <= 1'b0;
    @(posedge clk);
  endtask

  // Sorted knots from a base and random interval lengths, some forced to zero.
  task automatic make_knots(output logic signed [KNOT_W-1:0] kn [5], input int max_step);
    int base, step;
    base = $urandom_range(0, 2 * 1024 * 1024) - 1024 * 1024;
    kn[0] = KNOT_W'(base);
    for (int i = 1; i < 5; i++) begin
      step = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, max_step);
      kn[i] = KNOT_W'(kn[i-1] + step);
    end
  endtask

  task automatic test_directed();
    logic signed [KNOT_W-1:0] kn [5];
    kn = '{0, 65536, 131072, 196608, 262144};
    for (int i = 0; i < 9; i++) send_eval(KNOT_W'(i * 32768 - 16384), kn);
    kn = '{-24'sd8388608, -24'sd8388608, 0, 24'sd8388607, 24'sd8388607};
    send_eval(-24'sd8388608, kn);
    send_eval(0, kn);
    send_eval(24'sd8388606, kn);
    send_eval(24'sd8388607, kn);
    kn = '{0, 0, 0, 65536, 65536};
    send_eval(0, kn);
    send_eval(32768, kn);
    kn = '{0, 0, 0, 0, 65536};
    send_eval(100, kn);
    kn = '{5, 5, 5, 5, 5};
    send_eval(5, kn);
    kn = '{0, 131072, 65536, 196608, 262144};
    send_eval(70000, kn);
    send_eval(-1, kn);
    kn = '{24'sd8388607, 0, 0, 0, -24'sd8388608};
    send_eval(24'sd8388607, kn);
    send_eval(-24'sd8388608, kn);
    kn = '{-24'sd8388608, -24'sd100, 24'sd100, 24'sd8388607, 24'sd8388607};
    send_eval(-24'sd1, kn);
    send_eval(24'sd8388607, kn);
    finish_send();
  endtask

  task automatic test_random_in_support(int count);
    logic signed [KNOT_W-1:0] kn [5];
    longint lo, hi;
    for (int i = 0; i < count; i++) begin
      make_knots(kn, ($urandom_range(0, 9) == 0) ? 1500000 : 200000);
      lo = kn[0] - 1000;
      hi = kn[4] + 1000;
      if (hi > 8388607) hi = 8388607;
      send_eval(KNOT_W'(lo + longint'($urandom_range(0, int'(hi - lo)))), kn);
    end
    finish_send();
  endtask

  task automatic test_random_noise(int count);
    logic signed [KNOT_W-1:0] kn [5];
    for (int i = 0; i < count; i++) begin
      for (int j = 0; j < 5; j++) kn[j] = KNOT_W'($urandom);
      if ($urandom_range(0, 1)) kn.sort();
      send_eval(KNOT_W'($urandom), kn);
    end
    finish_send();
  endtask

  always @(posedge clk) begin
    basis_res_t e;
    if (rst_n && out_valid) begin
      n_recv++;
      if (expected_q.size() == 0) begin
        $error("result with no pending transaction");
        n_fail++;
      end else begin
        e = expected_q.pop_front();
        if (e.sup) n_support++;
        if (e.err) n_order_err++;
        if (out_basis_value !== e.basis) begin
          $error("basis_value exp %0d got %0d", e.basis, out_basis_value); n_fail++;
        end
        if (out_in_support !== e.sup) begin
          $error("in_support exp %0d got %0d", e.sup, out_in_support); n_fail++;
        end
        if (out_span_index !== e.span) begin
          $error("span_index exp %0d got %0d", e.span, out_span_index); n_fail++;
        end
        if (out_knot_order_error !== e.err) begin
          $error("knot_order_error exp %0d got %0d", e.err, out_knot_order_error);
          n_fail++;
        end
      end
    end
  end

  // Watchdog: cycles without any accepted transaction on either side.
  always @(posedge clk) begin
    if ((start && !busy) || out_valid) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout after %0d idle cycles", idle_cycles);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random_in_support(750);
    test_random_noise(180);
    wait (expected_q.size() == 0);
    repeat (LAT + 10) @(posedge clk);
    $display("%0d evaluations sent, %0d checked: %0d in support, %0d with knots out of order",
             n_sent, n_recv, n_support, n_order_err);
    if (n_fail == 0 && expected_q.size() == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule
